// ----- src/affine_transform_inverse_defines.svh -----
// Assertion macros for the affine transform inverse block.
// No dependencies; included by the files that assert.
`ifndef AFFINE_TRANSFORM_INVERSE_DEFINES_SVH
`define AFFINE_TRANSFORM_INVERSE_DEFINES_SVH

// check cons in the same cycle as ante
`define ATI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define ATI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/ati_pkg.sv -----
// Shared constants and pipeline types for the affine transform inverse.
// No dependencies.
package ati_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ELEM_W        = 32;
	localparam int LANES         = 6;
	localparam int Q_W           = 33;
	localparam int DIV_STEPS     = Q_W;
	localparam int DEN_W         = 64;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [Q_W-1:0]   nlo;
		logic [Q_W-1:0]   quo;
		logic             ovf;
		logic             neg;
	} div_lane_t;

	typedef struct packed {
		logic                           sing;
		logic [DEN_W-1:0]               dm;
		logic [LANES-1:0][ELEM_W-1:0]   echo;
	} div_ctl_t;

endpackage

// ----- src/affine_transform_inverse.sv -----
// Throughput one word per cycle while the output is not stalled. Products, determinant,
// magnitudes, a divider load stage, then 33 restoring-division stages of one 65-bit
// subtract each run six quotients in parallel; a final stage saturates and signs them,
// or echoes the input on a singular matrix. A stalled output holds the whole pipeline;
// nothing is dropped or repeated. Reset (arst_n low, asynchronous) clears all valid bits;
// payload is not reset. Depends on ati_pkg and affine_transform_inverse_defines.svh.
`include "affine_transform_inverse_defines.svh"

module affine_transform_inverse #(
	parameter int FRAC_BITS = ati_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,  // in_a, in_b, in_c, in_d, in_tx, in_ty
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [191:0] m_axis_tdata,  // out_a, out_b, out_c, out_d, out_tx, out_ty
	output logic [1:0]   m_axis_tuser   // singular, overflow
);

	localparam int NW    = 64 + FRAC_BITS;
	localparam int LN    = ati_pkg::LANES;
	localparam int EW    = ati_pkg::ELEM_W;
	localparam int QW    = ati_pkg::Q_W;
	localparam int STEPS = ati_pkg::DIV_STEPS;

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: products
	logic                 vld_s1;
	logic signed [63:0]   prod_s1 [LN];
	logic [EW-1:0]        elem_s1 [LN];
	logic signed [EW-1:0] in_f    [LN];

	always_comb begin
		for (int k = 0; k < LN; k++) in_f[k] = s_axis_tdata[k*EW +: EW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= 64'(in_f[0]) * 64'(in_f[3]);
			prod_s1[1] <= 64'(in_f[1]) * 64'(in_f[2]);
			prod_s1[2] <= 64'(in_f[2]) * 64'(in_f[5]);
			prod_s1[3] <= 64'(in_f[3]) * 64'(in_f[4]);
			prod_s1[4] <= 64'(in_f[1]) * 64'(in_f[4]);
			prod_s1[5] <= 64'(in_f[0]) * 64'(in_f[5]);
			for (int k = 0; k < LN; k++) elem_s1[k] <= in_f[k];
		end
	end

	// stage 2: determinant and translation numerators
	logic          vld_s2;
	logic [64:0]   det_s2;
	logic [64:0]   tr_s2 [2];
	logic [EW-1:0] elem_s2 [LN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s2   <= {prod_s1[0][63], prod_s1[0]} - {prod_s1[1][63], prod_s1[1]};
			tr_s2[0] <= {prod_s1[2][63], prod_s1[2]} - {prod_s1[3][63], prod_s1[3]};
			tr_s2[1] <= {prod_s1[4][63], prod_s1[4]} - {prod_s1[5][63], prod_s1[5]};
			elem_s2  <= elem_s1;
		end
	end

	// stage 3: magnitudes and signs
	logic          vld_s3;
	logic [NW-1:0] nm_s3 [LN];
	logic [63:0]   dm_s3;
	logic [LN-1:0] neg_s3;
	logic          sing_s3;
	logic [EW-1:0] elem_s3 [LN];

	logic [NW-1:0] nm_c [LN];
	logic [LN-1:0] nneg_c;
	logic [64:0]   dabs_c;
	logic [32:0]   emag_c [4];
	logic [64:0]   tmag_c [2];
	logic [EW-1:0] lin_src [4];
	logic [3:0]    lin_flip;

	always_comb begin
		lin_src  = '{elem_s2[3], elem_s2[1], elem_s2[2], elem_s2[0]};
		lin_flip = 4'b0110;
		for (int k = 0; k < 4; k++) begin
			emag_c[k] = lin_src[k][EW-1] ? (33'd0 - {1'b1, lin_src[k]}) : {1'b0, lin_src[k]};
			nneg_c[k] = lin_src[k][EW-1] ^ lin_flip[k];
			nm_c[k]   = NW'(emag_c[k]) << (2 * FRAC_BITS);
		end
		for (int k = 0; k < 2; k++) begin
			tmag_c[k]     = tr_s2[k][64] ? (65'd0 - tr_s2[k]) : tr_s2[k];
			nneg_c[4 + k] = tr_s2[k][64];
			nm_c[4 + k]   = NW'(tmag_c[k][63:0]) << FRAC_BITS;
		end
		dabs_c = det_s2[64] ? (65'd0 - det_s2) : det_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm_s3   <= nm_c;
			dm_s3   <= dabs_c[63:0];
			neg_s3  <= nneg_c ^ {LN{det_s2[64]}};
			sing_s3 <= (det_s2 == 65'd0);
			elem_s3 <= elem_s2;
		end
	end

	// stage 4 onward: restoring division, one quotient bit per stage
	ati_pkg::div_lane_t lane_s [STEPS+1][LN];
	ati_pkg::div_ctl_t  ctl_s  [STEPS+1];
	logic               dvld_s [STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dvld_s[0] <= 1'b0;
		else if (en) dvld_s[0] <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LN; k++) begin
				lane_s[0][k].rem <= 64'(nm_s3[k] >> QW);
				lane_s[0][k].ovf <= 64'(nm_s3[k] >> QW) >= dm_s3;
				lane_s[0][k].nlo <= nm_s3[k][QW-1:0];
				lane_s[0][k].quo <= '0;
				lane_s[0][k].neg <= neg_s3[k];
				ctl_s[0].echo[k] <= elem_s3[k];
			end
			ctl_s[0].dm   <= dm_s3;
			ctl_s[0].sing <= sing_s3;
		end
	end

	for (genvar j = 1; j <= STEPS; j++) begin : g_div
		ati_pkg::div_lane_t nxt [LN];
		logic [64:0]        cand [LN];
		logic [64:0]        diff [LN];

		always_comb begin
			for (int k = 0; k < LN; k++) begin
				cand[k]     = {lane_s[j-1][k].rem, lane_s[j-1][k].nlo[QW-1]};
				diff[k]     = cand[k] - {1'b0, ctl_s[j-1].dm};
				nxt[k]      = lane_s[j-1][k];
				nxt[k].nlo  = lane_s[j-1][k].nlo << 1;
				nxt[k].rem  = diff[k][64] ? cand[k][63:0] : diff[k][63:0];
				nxt[k].quo  = {lane_s[j-1][k].quo[QW-2:0], !diff[k][64]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dvld_s[j] <= 1'b0;
			else if (en) dvld_s[j] <= dvld_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lane_s[j] <= nxt;
				ctl_s[j]  <= ctl_s[j-1];
			end
		end
	end

	// final stage: saturate, apply sign, select echo on singular
	logic [191:0]  res_q;
	logic [1:0]    flag_q;
	logic          m_valid_q;
	logic [191:0]  res_c;
	logic [LN-1:0] sat_c;
	logic [QW-1:0] lim_c [LN];
	logic [QW-1:0] val_c [LN];
	logic          negf_c [LN];

	always_comb begin
		for (int k = 0; k < LN; k++) begin
			negf_c[k] = lane_s[STEPS][k].neg &&
				(lane_s[STEPS][k].ovf || lane_s[STEPS][k].quo != '0);
			lim_c[k]  = negf_c[k] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
			sat_c[k]  = lane_s[STEPS][k].ovf || (lane_s[STEPS][k].quo > lim_c[k]);
			val_c[k]  = sat_c[k] ? lim_c[k] : lane_s[STEPS][k].quo;
			if (negf_c[k]) val_c[k] = QW'(0) - val_c[k];
			res_c[k*EW +: EW] = ctl_s[STEPS].sing ? ctl_s[STEPS].echo[k] : val_c[k][EW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (en) m_valid_q <= dvld_s[STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q  <= res_c;
			flag_q <= {!ctl_s[STEPS].sing && (sat_c != '0), ctl_s[STEPS].sing};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = res_q;
	assign m_axis_tuser  = flag_q;

	`ATI_ASSERT_NOW(a_sing_no_ovf, clk, arst_n, m_axis_tvalid && m_axis_tuser[0],
		!m_axis_tuser[1], "singular result reports overflow")
	`ATI_ASSERT_NOW(a_sing_zero_det, clk, arst_n, vld_s3 && sing_s3,
		dm_s3 == 64'd0, "singular flag with nonzero determinant")
	`ATI_ASSERT_NOW(a_rem_range, clk, arst_n,
		dvld_s[STEPS] && !ctl_s[STEPS].sing && !lane_s[STEPS][0].ovf,
		lane_s[STEPS][0].rem < ctl_s[STEPS].dm, "division remainder out of range")
	`ATI_ASSERT_NEXT(a_stall_hold, clk, arst_n, !en,
		$stable(vld_s1) && $stable(dvld_s[STEPS]), "pipeline moved during stall")

endmodule

// ----- test/tb.sv -----
// Self-checking bench for affine_transform_inverse: drives 2x3 Q16.16 transforms over the
// input stream and compares each output word with an inverse computed here at full width.
// Depends on ati_pkg and the affine_transform_inverse RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int F        = ati_pkg::FRAC_BITS_DEF;
	localparam int EW       = ati_pkg::ELEM_W;
	localparam int N_RAND   = 1800;
	localparam int IDLE_MAX = 5000;

	typedef struct {
		logic signed [EW-1:0] a, b, c, d, tx, ty;
	} xform_t;

	typedef struct packed {
		logic [EW-1:0] a, b, c, d, tx, ty;
		logic          singular;
		logic          overflow;
	} inverse_t;

	class inverse_board;
		inverse_t pending_q[$];
		int       n_bad;

		function logic [EW-1:0] div_sat(logic signed [127:0] num, logic signed [127:0] det,
			inout logic ovf);
			logic signed [127:0] q;
			q = num / det;
			if (q > 128'sh7FFF_FFFF) begin
				ovf = 1'b1;
				return 32'h7FFF_FFFF;
			end
			if (q < -128'sh8000_0000) begin
				ovf = 1'b1;
				return 32'h8000_0000;
			end
			return q[EW-1:0];
		endfunction

		function inverse_t invert(xform_t x);
			logic signed [127:0] a, b, c, d, tx, ty, det;
			inverse_t r;
			logic ovf;
			a = x.a; b = x.b; c = x.c; d = x.d; tx = x.tx; ty = x.ty;
			det = a * d - b * c;
			ovf = 1'b0;
			if (det == 0) begin
				r = '{x.a, x.b, x.c, x.d, x.tx, x.ty, 1'b1, 1'b0};
				return r;
			end
			r.a  = div_sat(d <<< (2 * F), det, ovf);
			r.b  = div_sat((-b) <<< (2 * F), det, ovf);
			r.c  = div_sat((-c) <<< (2 * F), det, ovf);
			r.d  = div_sat(a <<< (2 * F), det, ovf);
			r.tx = div_sat((c * ty - d * tx) <<< F, det, ovf);
			r.ty = div_sat((b * tx - a * ty) <<< F, det, ovf);
			r.singular = 1'b0;
			r.overflow = ovf;
			return r;
		endfunction

		function void note_input(xform_t x);
			pending_q.push_back(invert(x));
		endfunction

		function void check_result(logic [191:0] data, logic [1:0] user);
			inverse_t e;
			inverse_t g;
			if (pending_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected output word %h user %b", data, user);
				return;
			end
			e = pending_q.pop_front();
			g = '{data[31:0], data[63:32], data[95:64], data[127:96], data[159:128],
				data[191:160], user[0], user[1]};
			if (g !== e) begin
				n_bad++;
				if (n_bad <= 10)
					$display("mismatch: exp %h %h %h %h %h %h s%b o%b got %h %h %h %h %h %h s%b o%b",
						e.a, e.b, e.c, e.d, e.tx, e.ty, e.singular, e.overflow,
						g.a, g.b, g.c, g.d, g.tx, g.ty, g.singular, g.overflow);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [191:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	inverse_board sb = new();
	int           n_sent;
	int           idle_cycles;
	int           rx_stall;
	int           rx_gap;
	bit           rx_hold_done;

	affine_transform_inverse u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic signed [EW-1:0] near_one();
		return EW'($urandom_range(0, 524288)) - 32'sd262144;
	endfunction

	function automatic xform_t rand_xform();
		xform_t x;
		int k;
		int mode;
		mode = $urandom_range(0, 9);
		x = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		case (mode)
			0, 1, 2: ;
			3, 4, 5: begin
				x.a = near_one(); x.b = near_one(); x.c = near_one(); x.d = near_one();
			end
			6, 7: begin
				k    = $urandom_range(0, 65535) - 32768;
				x.a  = $urandom_range(0, 65535) - 32768;
				x.c  = $urandom_range(0, 65535) - 32768;
				x.b  = x.a * k;
				x.d  = x.c * k;
			end
			default: begin
				x.a = $urandom_range(0, 15) - 8; x.b = $urandom_range(0, 15) - 8;
				x.c = $urandom_range(0, 15) - 8; x.d = $urandom_range(0, 15) - 8;
			end
		endcase
		return x;
	endfunction

	task automatic send_xform(xform_t x);
		bit rdy;
		repeat (pick_gap()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {x.ty, x.tx, x.d, x.c, x.b, x.a};
		do begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end while (!rdy);
		sb.note_input(x);
		n_sent++;
	endtask

	// receiver: random backpressure plus one long hold while the sender keeps going
	always @(posedge clk) begin
		if (!rx_hold_done && n_sent >= 700) begin
			rx_hold_done <= 1'b1;
			rx_stall     <= 400;
			m_axis_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall      <= rx_stall - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap        <= rx_gap - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < 25) begin
			rx_gap        <= pick_gap();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(negedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= IDLE_MAX) begin
			$display("FAIL affine_transform_inverse");
			$finish;
		end
	end

	initial begin
		xform_t dir[$];
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		rx_stall      = 0;
		rx_gap        = 0;
		rx_hold_done  = 1'b0;
		n_sent        = 0;
		idle_cycles   = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir.push_back('{32'sh10000, 0, 0, 32'sh10000, 0, 0});
		dir.push_back('{0, 0, 0, 0, 0, 0});
		dir.push_back('{32'sh20000, 32'sh40000, 32'sh10000, 32'sh20000, 32'sh7FFFFFFF, -1});
		dir.push_back('{1, 0, 0, 1, 5, -5});
		dir.push_back('{32'sh7FFFFFFF, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
		dir.push_back('{32'sh80000000, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000});
		dir.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 2});
		dir.push_back('{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, -1, 1});
		dir.push_back('{-1, -1, -1, -1, -1, -1});
		dir.push_back('{0, 32'sh10000, -32'sh10000, 0, 32'sh30000, -32'sh20000});
		dir.push_back('{32'sh8000, 0, 0, -32'sh8000, 32'sh7FFFFFFF, 32'sh80000000});
		dir.push_back('{32'sh1000000, 0, 0, 32'sh1000000, 32'sh80000000, 32'sh7FFFFFFF});
		dir.push_back('{32'sh100, 0, 0, 32'sh100, 0, 0});
		dir.push_back('{32'sh40000, 32'sh10000, 32'sh30000, 32'sh20000, 32'sh12345, 32'sh6789});
		dir.push_back('{32'sh55555555, 32'shAAAAAAAA, 32'sh33333333, 32'shCCCCCCCC, 32'h0F0F0F0F,
			32'shF0F0F0F0});
		dir.push_back('{-32'sh10000, 0, 0, 32'sh10000, 32'sh7FFF0000, 32'sh80010000});
		foreach (dir[i]) send_xform(dir[i]);

		for (int i = 0; i < N_RAND; i++) begin
			if (i == 1200) begin
				s_axis_tvalid <= 1'b0;
				while (sb.pending_q.size() != 0) @(posedge clk);
			end
			send_xform(rand_xform());
		end
		s_axis_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.n_bad == 0 && sb.pending_q.size() == 0) begin
			$display("PASS affine_transform_inverse");
		end else begin
			$display("FAIL affine_transform_inverse");
		end
		$finish;
	end
endmodule
